// ===== rtl/tsm_pkg.sv =====
package tsm_pkg;

    // Configuration register map
    typedef enum logic [2:0] {
        REG_SX_GAIN_X = 3'd0,
        REG_SX_GAIN_Y = 3'd1,
        REG_SX_OFFSET = 3'd2,
        REG_SY_GAIN_X = 3'd3,
        REG_SY_GAIN_Y = 3'd4,
        REG_SY_OFFSET = 3'd5,
        REG_RAW_MIN   = 3'd6,
        REG_RAW_MAX   = 3'd7
    } cfg_reg_e;

    localparam int CFG_DATA_BITS   = 32;
    localparam int RAW_LIMIT_BITS  = 12;
    localparam int MEDIAN_OUT_BITS = 12;
    localparam int SCREEN_BITS     = 16;

    localparam logic [RAW_LIMIT_BITS-1:0] RAW_MIN_RESET = 12'd10;
    localparam logic [RAW_LIMIT_BITS-1:0] RAW_MAX_RESET = 12'd1950;
    localparam logic [SCREEN_BITS-1:0]    SCREEN_LIMIT  = 16'd60000;

    // Divide by 1000000: q = (n * RECIP_MULT) >> RECIP_SHIFT, exact for n < 2^31
    localparam logic [31:0] RECIP_MULT  = 32'd2251799814;
    localparam int          RECIP_SHIFT = 51;
    localparam int          NUM_BITS    = 31;
    localparam int          PROD_BITS   = NUM_BITS + 32;
    localparam int          QUOT_BITS   = PROD_BITS - RECIP_SHIFT;

    // Per-stage load strobes for the mapping pipeline
    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
    } pipe_en_t;

endpackage

// ===== rtl/tsm_median.sv =====
module tsm_median #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                   clk,
    input  logic                                   load,
    input  logic [SAMPLE_BITS-1:0]                 x0,
    input  logic [SAMPLE_BITS-1:0]                 x1,
    input  logic [SAMPLE_BITS-1:0]                 x2,
    input  logic [SAMPLE_BITS-1:0]                 y0,
    input  logic [SAMPLE_BITS-1:0]                 y1,
    input  logic [SAMPLE_BITS-1:0]                 y2,
    input  logic [tsm_pkg::RAW_LIMIT_BITS-1:0]     raw_min,
    input  logic [tsm_pkg::RAW_LIMIT_BITS-1:0]     raw_max,
    output logic [SAMPLE_BITS-1:0]                 med_x,
    output logic [SAMPLE_BITS-1:0]                 med_y,
    output logic                                   in_window
);

    localparam int CMP_BITS = (SAMPLE_BITS > tsm_pkg::RAW_LIMIT_BITS) ?
                              SAMPLE_BITS : tsm_pkg::RAW_LIMIT_BITS;

    function automatic logic [SAMPLE_BITS-1:0] median3(
        input logic [SAMPLE_BITS-1:0] a,
        input logic [SAMPLE_BITS-1:0] b,
        input logic [SAMPLE_BITS-1:0] c
    );
        logic ab;
        logic bc;
        logic ac;
        logic [SAMPLE_BITS-1:0] m;
        begin
            ab = a > b;
            bc = b > c;
            ac = a > c;
            if (ab)
            begin
                if (bc)
                    m = b;
                else
                    m = ac ? c : a;
            end
            else
            begin
                if (ac)
                    m = a;
                else
                    m = bc ? c : b;
            end
            return m;
        end
    endfunction

    logic [SAMPLE_BITS-1:0] mx;
    logic [SAMPLE_BITS-1:0] my;
    logic [CMP_BITS-1:0]    mx_w;
    logic [CMP_BITS-1:0]    my_w;
    logic [CMP_BITS-1:0]    lo_w;
    logic [CMP_BITS-1:0]    hi_w;
    logic                   ok;

    logic [SAMPLE_BITS-1:0] med_x_reg;
    logic [SAMPLE_BITS-1:0] med_y_reg;
    logic                   in_window_reg;

    // Medians and window check
    always_comb
    begin
        mx   = median3(x0, x1, x2);
        my   = median3(y0, y1, y2);
        mx_w = CMP_BITS'(mx);
        my_w = CMP_BITS'(my);
        lo_w = CMP_BITS'(raw_min);
        hi_w = CMP_BITS'(raw_max);
        ok   = !(mx_w > hi_w || mx_w < lo_w || my_w > hi_w || my_w < lo_w);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            med_x_reg     <= mx;
            med_y_reg     <= my;
            in_window_reg <= ok;
        end
    end

    assign med_x     = med_x_reg;
    assign med_y     = med_y_reg;
    assign in_window = in_window_reg;

endmodule

// ===== rtl/tsm_axis.sv =====
module tsm_axis #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                               clk,
    input  tsm_pkg::pipe_en_t                  en,
    input  logic [31:0]                        gain_x,
    input  logic [31:0]                        gain_y,
    input  logic [31:0]                        offset,
    input  logic [SAMPLE_BITS-1:0]             raw_x,
    input  logic [SAMPLE_BITS-1:0]             raw_y,
    output logic [tsm_pkg::SCREEN_BITS-1:0]    screen
);

    logic [31:0]                       prod_x_reg;
    logic [31:0]                       prod_y_reg;
    logic [31:0]                       sum_reg;
    logic [tsm_pkg::PROD_BITS-1:0]     recip_reg;
    logic                              neg_reg;
    logic [tsm_pkg::QUOT_BITS-1:0]     quot;
    logic [tsm_pkg::SCREEN_BITS-1:0]   quot_w;

    // Weighted raw terms, kept modulo 2^32
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            prod_x_reg <= 32'(gain_x * 32'(raw_x));
            prod_y_reg <= 32'(gain_y * 32'(raw_y));
        end
    end

    // Wrapping affine sum
    always_ff @(posedge clk)
    begin
        if (en.s4)
            sum_reg <= 32'(prod_x_reg + prod_y_reg + offset);
    end

    // Reciprocal multiply for the divide by one million
    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            recip_reg <= tsm_pkg::PROD_BITS'(sum_reg[tsm_pkg::NUM_BITS-1:0]) *
                         tsm_pkg::PROD_BITS'(tsm_pkg::RECIP_MULT);
            neg_reg   <= sum_reg[31];
        end
    end

    // Quotient, negative and over-range clamp to zero
    always_comb
    begin
        quot   = recip_reg[tsm_pkg::PROD_BITS-1:tsm_pkg::RECIP_SHIFT];
        quot_w = tsm_pkg::SCREEN_BITS'(quot);
        if (neg_reg || quot_w > tsm_pkg::SCREEN_LIMIT)
            screen = '0;
        else
            screen = quot_w;
    end

endmodule

// ===== rtl/touch_sample_median_mapper_core.sv =====
// Touch sample median filter and calibration mapper. Sample pairs are taken
// one per clock while sample_stall is low; the first two pairs of each set of
// three are held and the third produces one result word carrying the X/Y
// medians, a window flag and the calibrated screen coordinates (zero when
// rejected, negative or above 60000). A set passes through set, median,
// multiply, sum, reciprocal-multiply and output registers in turn; each stage
// moves on independently, so sample_stall rises only when every stage holds
// a word and the output word is stalled. Pairs that only fill a set are
// never stalled by a waiting result beyond that. The divide by one million
// is a 31x32 reciprocal multiply. Configuration is accepted on every cycle.
module touch_sample_median_mapper_core #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // sample channel
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic                                 first_pair,
    input  logic [SAMPLE_BITS-1:0]               x_sample,
    input  logic [SAMPLE_BITS-1:0]               y_sample,
    // result channel
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic                                 accepted,
    output logic [tsm_pkg::MEDIAN_OUT_BITS-1:0]  median_x,
    output logic [tsm_pkg::MEDIAN_OUT_BITS-1:0]  median_y,
    output logic [tsm_pkg::SCREEN_BITS-1:0]      disp_x,
    output logic [tsm_pkg::SCREEN_BITS-1:0]      disp_y,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  tsm_pkg::cfg_reg_e                    cfg_index,
    input  logic [tsm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    // Configuration registers
    logic [31:0]                         sx_gain_x_reg;
    logic [31:0]                         sx_gain_y_reg;
    logic [31:0]                         sx_offset_reg;
    logic [31:0]                         sy_gain_x_reg;
    logic [31:0]                         sy_gain_y_reg;
    logic [31:0]                         sy_offset_reg;
    logic [tsm_pkg::RAW_LIMIT_BITS-1:0]  raw_min_reg;
    logic [tsm_pkg::RAW_LIMIT_BITS-1:0]  raw_max_reg;

    // Set collection
    logic [1:0]              pair_count_reg;
    logic [1:0]              pair_count_next;
    logic [1:0]              eff_count;
    logic [SAMPLE_BITS-1:0]  held_x0_reg;
    logic [SAMPLE_BITS-1:0]  held_x1_reg;
    logic [SAMPLE_BITS-1:0]  held_y0_reg;
    logic [SAMPLE_BITS-1:0]  held_y1_reg;
    logic                    take;
    logic                    accept;

    // Stage 1: the three pairs of a complete set
    logic                    s1_valid_reg;
    logic [SAMPLE_BITS-1:0]  s1_x0_reg;
    logic [SAMPLE_BITS-1:0]  s1_x1_reg;
    logic [SAMPLE_BITS-1:0]  s1_x2_reg;
    logic [SAMPLE_BITS-1:0]  s1_y0_reg;
    logic [SAMPLE_BITS-1:0]  s1_y1_reg;
    logic [SAMPLE_BITS-1:0]  s1_y2_reg;

    // Stage 2 (inside the median unit) onwards
    logic                    s2_valid_reg;
    logic [SAMPLE_BITS-1:0]  s2_med_x;
    logic [SAMPLE_BITS-1:0]  s2_med_y;
    logic                    s2_ok;
    logic                    s3_valid_reg;
    logic [SAMPLE_BITS-1:0]  s3_med_x_reg;
    logic [SAMPLE_BITS-1:0]  s3_med_y_reg;
    logic                    s3_ok_reg;
    logic                    s4_valid_reg;
    logic [SAMPLE_BITS-1:0]  s4_med_x_reg;
    logic [SAMPLE_BITS-1:0]  s4_med_y_reg;
    logic                    s4_ok_reg;
    logic                    s5_valid_reg;
    logic [SAMPLE_BITS-1:0]  s5_med_x_reg;
    logic [SAMPLE_BITS-1:0]  s5_med_y_reg;
    logic                    s5_ok_reg;

    logic                                 result_valid_reg;
    logic                                 accepted_reg;
    logic [tsm_pkg::MEDIAN_OUT_BITS-1:0]  median_x_reg;
    logic [tsm_pkg::MEDIAN_OUT_BITS-1:0]  median_y_reg;
    logic [tsm_pkg::SCREEN_BITS-1:0]      disp_x_reg;
    logic [tsm_pkg::SCREEN_BITS-1:0]      disp_y_reg;

    logic [tsm_pkg::SCREEN_BITS-1:0]      map_x;
    logic [tsm_pkg::SCREEN_BITS-1:0]      map_y;

    // Per-stage room and load strobes
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
    logic ld2, ld6;
    tsm_pkg::pipe_en_t map_en;

    assign rdy6 = !result_valid_reg || !result_stall;
    assign rdy5 = !s5_valid_reg || rdy6;
    assign rdy4 = !s4_valid_reg || rdy5;
    assign rdy3 = !s3_valid_reg || rdy4;
    assign rdy2 = !s2_valid_reg || rdy3;
    assign rdy1 = !s1_valid_reg || rdy2;

    assign ld2       = s1_valid_reg && rdy2;
    assign map_en.s3 = s2_valid_reg && rdy3;
    assign map_en.s4 = s3_valid_reg && rdy4;
    assign map_en.s5 = s4_valid_reg && rdy5;
    assign ld6       = s5_valid_reg && rdy6;

    assign sample_stall = !rdy1;
    assign accept       = sample_valid && rdy1;
    assign cfg_ready    = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_gain_x_reg <= '0;
            sx_gain_y_reg <= '0;
            sx_offset_reg <= '0;
            sy_gain_x_reg <= '0;
            sy_gain_y_reg <= '0;
            sy_offset_reg <= '0;
            raw_min_reg   <= tsm_pkg::RAW_MIN_RESET;
            raw_max_reg   <= tsm_pkg::RAW_MAX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tsm_pkg::REG_SX_GAIN_X: sx_gain_x_reg <= cfg_data;
                tsm_pkg::REG_SX_GAIN_Y: sx_gain_y_reg <= cfg_data;
                tsm_pkg::REG_SX_OFFSET: sx_offset_reg <= cfg_data;
                tsm_pkg::REG_SY_GAIN_X: sy_gain_x_reg <= cfg_data;
                tsm_pkg::REG_SY_GAIN_Y: sy_gain_y_reg <= cfg_data;
                tsm_pkg::REG_SY_OFFSET: sy_offset_reg <= cfg_data;
                tsm_pkg::REG_RAW_MIN:
                    raw_min_reg <= cfg_data[tsm_pkg::RAW_LIMIT_BITS-1:0];
                tsm_pkg::REG_RAW_MAX:
                    raw_max_reg <= cfg_data[tsm_pkg::RAW_LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Set position of the incoming pair
    always_comb
    begin
        if (first_pair)
            eff_count = 2'd0;
        else if (pair_count_reg == 2'd3)
            eff_count = 2'd2;
        else
            eff_count = pair_count_reg;
        take            = accept && (eff_count == 2'd2);
        pair_count_next = (eff_count == 2'd2) ? 2'd0 : eff_count + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pair_count_reg <= 2'd0;
        else if (accept)
            pair_count_reg <= pair_count_next;
    end

    // Held pairs
    always_ff @(posedge clk)
    begin
        if (accept && eff_count == 2'd0)
        begin
            held_x0_reg <= x_sample;
            held_y0_reg <= y_sample;
        end
        if (accept && eff_count == 2'd1)
        begin
            held_x1_reg <= x_sample;
            held_y1_reg <= y_sample;
        end
        if (take)
        begin
            s1_x0_reg <= held_x0_reg;
            s1_x1_reg <= held_x1_reg;
            s1_x2_reg <= x_sample;
            s1_y0_reg <= held_y0_reg;
            s1_y1_reg <= held_y1_reg;
            s1_y2_reg <= y_sample;
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            s5_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_valid_reg <= take;
            if (rdy2)
                s2_valid_reg <= s1_valid_reg;
            if (rdy3)
                s3_valid_reg <= s2_valid_reg;
            if (rdy4)
                s4_valid_reg <= s3_valid_reg;
            if (rdy5)
                s5_valid_reg <= s4_valid_reg;
            if (rdy6)
                result_valid_reg <= s5_valid_reg;
        end
    end

    tsm_median #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_median (
        .clk       (clk),
        .load      (ld2),
        .x0        (s1_x0_reg),
        .x1        (s1_x1_reg),
        .x2        (s1_x2_reg),
        .y0        (s1_y0_reg),
        .y1        (s1_y1_reg),
        .y2        (s1_y2_reg),
        .raw_min   (raw_min_reg),
        .raw_max   (raw_max_reg),
        .med_x     (s2_med_x),
        .med_y     (s2_med_y),
        .in_window (s2_ok)
    );

    // Medians and window flag ride alongside the mapping stages
    always_ff @(posedge clk)
    begin
        if (map_en.s3)
        begin
            s3_med_x_reg <= s2_med_x;
            s3_med_y_reg <= s2_med_y;
            s3_ok_reg    <= s2_ok;
        end
        if (map_en.s4)
        begin
            s4_med_x_reg <= s3_med_x_reg;
            s4_med_y_reg <= s3_med_y_reg;
            s4_ok_reg    <= s3_ok_reg;
        end
        if (map_en.s5)
        begin
            s5_med_x_reg <= s4_med_x_reg;
            s5_med_y_reg <= s4_med_y_reg;
            s5_ok_reg    <= s4_ok_reg;
        end
    end

    tsm_axis #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_axis_x (
        .clk    (clk),
        .en     (map_en),
        .gain_x (sx_gain_x_reg),
        .gain_y (sx_gain_y_reg),
        .offset (sx_offset_reg),
        .raw_x  (s2_med_x),
        .raw_y  (s2_med_y),
        .screen (map_x)
    );

    tsm_axis #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_axis_y (
        .clk    (clk),
        .en     (map_en),
        .gain_x (sy_gain_x_reg),
        .gain_y (sy_gain_y_reg),
        .offset (sy_offset_reg),
        .raw_x  (s2_med_x),
        .raw_y  (s2_med_y),
        .screen (map_y)
    );

    // Output word
    always_ff @(posedge clk)
    begin
        if (ld6)
        begin
            accepted_reg <= s5_ok_reg;
            median_x_reg <= tsm_pkg::MEDIAN_OUT_BITS'(s5_med_x_reg);
            median_y_reg <= tsm_pkg::MEDIAN_OUT_BITS'(s5_med_y_reg);
            disp_x_reg   <= s5_ok_reg ? map_x : '0;
            disp_y_reg   <= s5_ok_reg ? map_y : '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign accepted     = accepted_reg;
    assign median_x     = median_x_reg;
    assign median_y     = median_y_reg;
    assign disp_x       = disp_x_reg;
    assign disp_y       = disp_y_reg;

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        pair_count_reg != 2'd3)
        else $error("pair count reached an unused code");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !accepted |-> disp_x == '0 && disp_y == '0)
        else $error("rejected set carries screen coordinates");

    a_screen_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> disp_x <= tsm_pkg::SCREEN_LIMIT &&
                         disp_y <= tsm_pkg::SCREEN_LIMIT)
        else $error("screen coordinate above limit");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> s1_valid_reg && s2_valid_reg && s5_valid_reg &&
                         result_valid && result_stall)
        else $error("sample stalled with room in the pipeline");

endmodule
